FILE: hw/rtl/deq_pkg.sv
package deq_pkg;

    // Fixed field widths
    localparam int REQ_W  = 3;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;

    // Default sizes
    localparam int DEF_DEPTH      = 16;
    localparam int DEF_DATA_WIDTH = 32;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
    localparam logic [STAT_W-1:0] STAT_POP_EMPTY  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_PUSH_FULL  = 2'd2;

    // Request sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_RESP
    } deq_state_t;

    // Memory access strobes
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } deq_mem_cmd_t;

    // Response info handed to the output stage
    typedef struct packed {
        logic                load;
        logic                empty;
        logic [STAT_W-1:0]   status;
    } deq_rsp_t;

endpackage

FILE: hw/rtl/deq_mem.sv
module deq_mem #(
    parameter int DEPTH      = deq_pkg::DEF_DEPTH,
    parameter int DATA_WIDTH = deq_pkg::DEF_DATA_WIDTH
) (
    input  logic                       clk,
    input  deq_pkg::deq_mem_cmd_t      cmd,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [DATA_WIDTH-1:0]      wr_data,
    input  logic [$clog2(DEPTH)-1:0]   rd_front_addr,
    input  logic [$clog2(DEPTH)-1:0]   rd_back_addr,
    output logic [DATA_WIDTH-1:0]      rd_front_data,
    output logic [DATA_WIDTH-1:0]      rd_back_data
);
    import deq_pkg::*;

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    // Single write port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Two registered read ports
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_front_data <= mem[rd_front_addr];
            rd_back_data  <= mem[rd_back_addr];
        end
    end

endmodule

FILE: hw/rtl/deq_ctrl.sv
module deq_ctrl #(
    parameter int DEPTH      = deq_pkg::DEF_DEPTH,
    parameter int DATA_WIDTH = deq_pkg::DEF_DATA_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [deq_pkg::REQ_W-1:0]     req_type,
    input  logic [deq_pkg::VAL_W-1:0]     push_value,
    input  logic                          out_free,
    output deq_pkg::deq_mem_cmd_t         cmd,
    output logic [$clog2(DEPTH)-1:0]      wr_addr,
    output logic [DATA_WIDTH-1:0]         wr_data,
    output logic [$clog2(DEPTH)-1:0]      rd_front_addr,
    output logic [$clog2(DEPTH)-1:0]      rd_back_addr,
    output deq_pkg::deq_rsp_t             rsp,
    output logic [$clog2(DEPTH+1)-1:0]    count
);
    import deq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    deq_state_t          state_reg, state_next;
    logic [PTR_W-1:0]    front_reg, front_next;
    logic [CNT_W-1:0]    occ_reg, occ_next;
    logic [STAT_W-1:0]   status_reg, status_next;

    logic                accept;
    logic                full;
    logic                empty;
    logic                push_en;
    logic [PTR_W-1:0]    front_dec;
    logic [PTR_W-1:0]    front_inc;
    logic [SUM_W-1:0]    tail_sum;
    logic [SUM_W-1:0]    tail_wrap;
    logic [SUM_W-1:0]    back_sum;
    logic [SUM_W-1:0]    back_wrap;

    assign accept = s_tvalid && s_tready;
    assign full   = (occ_reg >= CNT_W'(DEPTH));
    assign empty  = (occ_reg == '0);

    // Circular pointer arithmetic
    assign front_dec = (front_reg == '0) ? PTR_W'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == PTR_W'(DEPTH - 1)) ? '0 : front_reg + 1'b1;

    // Slot after the last element
    assign tail_sum  = SUM_W'(front_reg) + SUM_W'(occ_reg);
    assign tail_wrap = (tail_sum >= SUM_W'(DEPTH)) ? tail_sum - SUM_W'(DEPTH) : tail_sum;

    // Last element, valid only when not empty
    assign back_sum  = tail_sum - 1'b1;
    assign back_wrap = (back_sum >= SUM_W'(DEPTH)) ? back_sum - SUM_W'(DEPTH) : back_sum;

    // Stored word keeps the low DATA_WIDTH bits, zero above bit 31
    generate
        if (DATA_WIDTH > VAL_W)
        begin : g_wide
            assign wr_data = {{(DATA_WIDTH - VAL_W){1'b0}}, push_value};
        end
        else
        begin : g_narrow
            assign wr_data = push_value[DATA_WIDTH-1:0];
        end
    endgenerate

    // Request decode: pointer, count, status and write slot
    always_comb
    begin
        front_next  = front_reg;
        occ_next    = occ_reg;
        status_next = status_reg;
        push_en     = 1'b0;
        wr_addr     = tail_wrap[PTR_W-1:0];
        if (accept)
        begin
            status_next = STAT_OK;
            case (req_type)
                REQ_PUSH_FRONT:
                begin
                    wr_addr = front_dec;
                    if (full)
                    begin
                        status_next = STAT_PUSH_FULL;
                    end
                    else
                    begin
                        push_en    = 1'b1;
                        front_next = front_dec;
                        occ_next   = occ_reg + 1'b1;
                    end
                end
                REQ_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = STAT_PUSH_FULL;
                    end
                    else
                    begin
                        push_en  = 1'b1;
                        occ_next = occ_reg + 1'b1;
                    end
                end
                REQ_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = STAT_POP_EMPTY;
                    end
                    else
                    begin
                        front_next = front_inc;
                        occ_next   = occ_reg - 1'b1;
                    end
                end
                REQ_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next = STAT_POP_EMPTY;
                    end
                    else
                    begin
                        occ_next = occ_reg - 1'b1;
                    end
                end
                REQ_CLEAR:
                begin
                    front_next = '0;
                    occ_next   = '0;
                end
                default:
                begin
                    front_next = front_reg;
                end
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        s_tready   = 1'b0;
        cmd.rd_en  = 1'b0;
        cmd.wr_en  = push_en;
        rsp.load   = 1'b0;
        rsp.empty  = empty;
        rsp.status = status_reg;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_READ:
            begin
                cmd.rd_en = 1'b1;
            end
            ST_RESP:
            begin
                rsp.load = out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign rd_front_addr = front_reg;
    assign rd_back_addr  = empty ? front_reg : back_wrap[PTR_W-1:0];
    assign count         = occ_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            front_reg  <= '0;
            occ_reg    <= '0;
            status_reg <= STAT_OK;
        end
        else
        begin
            state_reg  <= state_next;
            front_reg  <= front_next;
            occ_reg    <= occ_next;
            status_reg <= status_next;
        end
    end

    // Occupancy never goes past the capacity
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(DEPTH))
        else $error("occupancy above capacity");

    // A dropped push leaves a full queue behind
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ && status_reg == STAT_PUSH_FULL)
        |-> occ_reg == CNT_W'(DEPTH))
        else $error("push flagged full on a queue with room");

    // An ignored pop leaves an empty queue behind
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ && status_reg == STAT_POP_EMPTY) |-> occ_reg == '0)
        else $error("pop flagged empty on a non-empty queue");

    // Writes only on an accepted request, never beside a read
    a_wr_gate: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> (accept && !cmd.rd_en))
        else $error("memory write outside request accept");

    // Each accepted request is followed by the read state with the read strobe
    a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_READ && cmd.rd_en))
        else $error("read cycle missing after accept");

endmodule

FILE: hw/rtl/double_ended_queue_unit.sv
// Bounded double-ended queue of DEPTH signed words held in a circular buffer
// in one synchronous memory (one write port, two registered read ports). Each
// word on the input stream is a request: push front, push back, pop front,
// pop back or clear, coded in s_tuser. Each request yields one result word
// with the front and back values, the element count and a status (ok, pop on
// empty ignored, push on full dropped). Front and back read zero when empty.
// A request is handled in order: the pointers are updated and the entry written,
// then the front and back entries are read from the memory, then the output
// register is loaded. The next request is taken while a result still
// waits on the output; a stalled output holds the sequencer in its last step.
module double_ended_queue_unit #(
    parameter int DEPTH      = deq_pkg::DEF_DEPTH,
    parameter int DATA_WIDTH = deq_pkg::DEF_DATA_WIDTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // push_value
    input  logic [deq_pkg::VAL_W-1:0]              s_tdata,
    // req_type
    input  logic [deq_pkg::REQ_W-1:0]              s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // front_value, back_value, element_count, zero pad
    output logic [((2*deq_pkg::VAL_W+$clog2(DEPTH+1)+7)/8)*8-1:0] m_tdata,
    // status
    output logic [deq_pkg::STAT_W-1:0]             m_tuser
);
    import deq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    deq_mem_cmd_t          cmd;
    deq_rsp_t              rsp;
    logic [PTR_W-1:0]      wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [PTR_W-1:0]      rd_front_addr;
    logic [PTR_W-1:0]      rd_back_addr;
    logic [DATA_WIDTH-1:0] rd_front_data;
    logic [DATA_WIDTH-1:0] rd_back_data;
    logic [CNT_W-1:0]      count;
    logic                  out_free;
    logic [VAL_W-1:0]      front_ext;
    logic [VAL_W-1:0]      back_ext;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [VAL_W-1:0]      front_reg;
    logic [VAL_W-1:0]      back_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [STAT_W-1:0]     status_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    deq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .req_type      (s_tuser),
        .push_value    (s_tdata),
        .out_free      (out_free),
        .cmd           (cmd),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_front_addr (rd_front_addr),
        .rd_back_addr  (rd_back_addr),
        .rsp           (rsp),
        .count         (count)
    );

    deq_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .clk           (clk),
        .cmd           (cmd),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_front_addr (rd_front_addr),
        .rd_back_addr  (rd_back_addr),
        .rd_front_data (rd_front_data),
        .rd_back_data  (rd_back_data)
    );

    // Sign-extend narrower stored words to the reported width, truncate wider ones
    generate
        if (DATA_WIDTH >= VAL_W)
        begin : g_trunc
            assign front_ext = rd_front_data[VAL_W-1:0];
            assign back_ext  = rd_back_data[VAL_W-1:0];
        end
        else
        begin : g_sext
            assign front_ext = {{(VAL_W - DATA_WIDTH){rd_front_data[DATA_WIDTH-1]}},
                                rd_front_data};
            assign back_ext  = {{(VAL_W - DATA_WIDTH){rd_back_data[DATA_WIDTH-1]}},
                                rd_back_data};
        end
    endgenerate

    // Output valid
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (rsp.load)
        begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (rsp.load)
        begin
            front_reg  <= rsp.empty ? '0 : front_ext;
            back_reg   <= rsp.empty ? '0 : back_ext;
            count_reg  <= count;
            status_reg <= rsp.status;
        end
    end

    // Pack the result word
    always_comb
    begin
        m_tdata                      = '0;
        m_tdata[VAL_W-1:0]           = front_reg;
        m_tdata[2*VAL_W-1:VAL_W]     = back_reg;
        m_tdata[2*VAL_W +: CNT_W]    = count_reg;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;

    // A result is loaded only into a free output slot
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.load |-> (!m_tvalid_reg || m_tready))
        else $error("result overwrote a pending output word");

    // An empty queue reports zero front and back
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) && count_reg == '0 |-> front_reg == '0 && back_reg == '0)
        else $error("empty queue reported nonzero values");

    // No new request while a result is waiting to be loaded
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.load |-> !s_tready)
        else $error("request taken during result load");

endmodule

FILE: test/double_ended_queue_unit_tb.sv
module double_ended_queue_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;

    localparam int DEPTH        = DEF_DEPTH;
    localparam int IDX_W        = $clog2(DEPTH);
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int OUT_W        = ((2 * VAL_W + CNT_W + 7) / 8) * 8;
    localparam int RAND_WORDS   = 1724;
    localparam int LONG_HOLD    = 120;
    localparam int DRAIN_CYCLES = 20;
    localparam int IDLE_LIMIT   = 2000;

    // Request codes the block treats as no operation
    localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd5;
    localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

    localparam logic [VAL_W-1:0] WORD_MIN  = 32'h8000_0000;
    localparam logic [VAL_W-1:0] WORD_MAX  = 32'h7fff_ffff;
    localparam logic [VAL_W-1:0] WORD_ONES = 32'hffff_ffff;
    localparam logic [VAL_W-1:0] WORD_ZERO = 32'h0000_0000;

    // What one result word reports about the queue
    typedef struct packed {
        logic signed [VAL_W-1:0] front;
        logic signed [VAL_W-1:0] back;
        logic [CNT_W-1:0]        count;
        logic [STAT_W-1:0]       status;
    } deque_view_t;

    // One line of the directed plan; view is used only where typed is set
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic [VAL_W-1:0] value;
        logic [4:0]       reps;
        logic             rand_value;
        logic             typed;
        deque_view_t      view;
    } plan_row_t;

    typedef enum {SEQ_FILL, SEQ_DRAIN, SEQ_MIXED, SEQ_NOISE} seq_kind_t;

    localparam int PLAN_ROWS = 13;
    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        // empty queue: both pops are flagged
        '{REQ_POP_FRONT,  WORD_ZERO, 5'd1, 1'b0, 1'b1,
          '{WORD_ZERO, WORD_ZERO, 5'd0, STAT_POP_EMPTY}},
        '{REQ_POP_BACK,   WORD_ONES, 5'd1, 1'b0, 1'b1,
          '{WORD_ZERO, WORD_ZERO, 5'd0, STAT_POP_EMPTY}},
        // value extremes at both ends
        '{REQ_PUSH_BACK,  WORD_MIN,  5'd1, 1'b0, 1'b1,
          '{WORD_MIN, WORD_MIN, 5'd1, STAT_OK}},
        '{REQ_PUSH_FRONT, WORD_MAX,  5'd1, 1'b0, 1'b1,
          '{WORD_MAX, WORD_MIN, 5'd2, STAT_OK}},
        // spare codes leave the queue alone
        '{REQ_SPARE_LO,   WORD_ONES, 5'd1, 1'b0, 1'b1,
          '{WORD_MAX, WORD_MIN, 5'd2, STAT_OK}},
        '{REQ_SPARE_HI,   WORD_ZERO, 5'd1, 1'b0, 1'b1,
          '{WORD_MAX, WORD_MIN, 5'd2, STAT_OK}},
        '{REQ_POP_BACK,   WORD_ZERO, 5'd1, 1'b0, 1'b1,
          '{WORD_MAX, WORD_MAX, 5'd1, STAT_OK}},
        '{REQ_POP_FRONT,  WORD_ZERO, 5'd1, 1'b0, 1'b1,
          '{WORD_ZERO, WORD_ZERO, 5'd0, STAT_OK}},
        // fill from both ends, wrapping the front pointer
        '{REQ_PUSH_FRONT, WORD_ZERO, 5'd8, 1'b1, 1'b0, '0},
        '{REQ_PUSH_BACK,  WORD_ZERO, 5'd8, 1'b1, 1'b0, '0},
        // push on full is dropped
        '{REQ_PUSH_FRONT, WORD_ONES, 5'd1, 1'b0, 1'b0, '0},
        '{REQ_CLEAR,      WORD_MAX,  5'd1, 1'b0, 1'b1,
          '{WORD_ZERO, WORD_ZERO, 5'd0, STAT_OK}},
        '{REQ_PUSH_BACK,  WORD_ONES, 5'd1, 1'b0, 1'b1,
          '{WORD_ONES, WORD_ONES, 5'd1, STAT_OK}}
    };

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [VAL_W-1:0]   s_tdata;
    logic [REQ_W-1:0]   s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [OUT_W-1:0]   m_tdata;
    logic [STAT_W-1:0]  m_tuser;

    double_ended_queue_unit #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (VAL_W)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Predictor state: circular store, head index and fill level
    logic [VAL_W-1:0] slots [DEPTH];
    logic [IDX_W-1:0] head_idx;
    logic [CNT_W-1:0] fill_lvl;

    deque_view_t  pending [$];
    int unsigned  err_cnt;
    int unsigned  sent_cnt;
    int unsigned  push_cnt, pop_cnt, full_cnt, empty_cnt, clear_cnt, peak_fill;
    bit           s_steady;

    // Apply one request to the predicted queue and report the resulting view
    function automatic deque_view_t deque_apply(input logic [REQ_W-1:0] req,
                                                input logic [VAL_W-1:0] value);
        deque_view_t      view;
        logic [IDX_W-1:0] slot;
        view.status = STAT_OK;
        case (req)
            REQ_PUSH_FRONT, REQ_PUSH_BACK:
            begin
                if (fill_lvl == DEPTH)
                begin
                    view.status = STAT_PUSH_FULL;
                    full_cnt++;
                end
                else
                begin
                    if (req == REQ_PUSH_FRONT)
                    begin
                        head_idx = head_idx - 1'b1;
                        slot = head_idx;
                    end
                    else
                    begin
                        slot = head_idx + IDX_W'(fill_lvl);
                    end
                    slots[slot] = value;
                    fill_lvl++;
                    push_cnt++;
                end
            end
            REQ_POP_FRONT, REQ_POP_BACK:
            begin
                if (fill_lvl == 0)
                begin
                    view.status = STAT_POP_EMPTY;
                    empty_cnt++;
                end
                else
                begin
                    if (req == REQ_POP_FRONT)
                        head_idx = head_idx + 1'b1;
                    fill_lvl--;
                    pop_cnt++;
                end
            end
            REQ_CLEAR:
            begin
                head_idx = '0;
                fill_lvl = '0;
                clear_cnt++;
            end
            default: ;
        endcase
        if (fill_lvl > peak_fill)
            peak_fill = fill_lvl;
        if (fill_lvl == 0)
        begin
            view.front = '0;
            view.back  = '0;
        end
        else
        begin
            slot = head_idx + IDX_W'(fill_lvl - 1'b1);
            view.front = slots[head_idx];
            view.back  = slots[slot];
        end
        view.count = fill_lvl;
        return view;
    endfunction

    // Push values lean toward the extremes
    function automatic logic [VAL_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return WORD_ZERO;
            3: return WORD_ONES;
            default: return $urandom;
        endcase
    endfunction

    function automatic seq_kind_t pick_kind();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return SEQ_FILL;
        else if (r < 70)
            return SEQ_DRAIN;
        else if (r < 90)
            return SEQ_MIXED;
        return SEQ_NOISE;
    endfunction

    // Fill runs are mostly pushes, drain runs mostly pops
    function automatic logic [REQ_W-1:0] pick_req(input seq_kind_t kind);
        bit at_back;
        at_back = $urandom_range(0, 1);
        case (kind)
            SEQ_FILL:
            begin
                if ($urandom_range(0, 9) < 8)
                    return at_back ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
                return at_back ? REQ_POP_BACK : REQ_POP_FRONT;
            end
            SEQ_DRAIN:
            begin
                if ($urandom_range(0, 9) < 8)
                    return at_back ? REQ_POP_BACK : REQ_POP_FRONT;
                if ($urandom_range(0, 3) == 0)
                    return REQ_CLEAR;
                return at_back ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
            end
            SEQ_MIXED:
                return REQ_W'($urandom_range(REQ_PUSH_FRONT, REQ_CLEAR));
            default:
                return REQ_W'($urandom_range(0, (1 << REQ_W) - 1));
        endcase
    endfunction

    // Offer one request word; valid stays high when the next gap is zero
    task automatic offer_word(input logic [REQ_W-1:0] req,
                              input logic [VAL_W-1:0] value,
                              input bit typed, input deque_view_t typed_view);
        int unsigned gap;
        deque_view_t view;
        gap = s_steady ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        view = deque_apply(req, value);
        pending.push_back(typed ? typed_view : view);
        sent_cnt++;
        if (sent_cnt % 64 == 0)
            s_steady = ($urandom_range(0, 3) == 0);
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stimulus: reset, directed plan, random runs, then drain
    initial
    begin : stimulus
        int unsigned k, r, left;
        seq_kind_t   kind;
        err_cnt   = 0;
        sent_cnt  = 0;
        push_cnt  = 0;
        pop_cnt   = 0;
        full_cnt  = 0;
        empty_cnt = 0;
        clear_cnt = 0;
        peak_fill = 0;
        s_steady  = 1'b0;
        head_idx  = '0;
        fill_lvl  = '0;
        kind      = SEQ_MIXED;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < PLAN_ROWS; r++)
        begin
            for (k = 0; k < PLAN[r].reps; k++)
                offer_word(PLAN[r].req, PLAN[r].rand_value ? pick_word() : PLAN[r].value,
                           PLAN[r].typed, PLAN[r].view);
        end

        left = 0;
        for (k = 0; k < RAND_WORDS; k++)
        begin
            if (left == 0)
            begin
                kind = pick_kind();
                left = $urandom_range(8, 40);
            end
            left--;
            offer_word(pick_req(kind), pick_word(), 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests: %0d pushes, %0d pops, %0d clears, peak fill %0d.",
                 sent_cnt, push_cnt, pop_cnt, clear_cnt, peak_fill);
        $display("Flagged cases: %0d pushes on full, %0d pops on empty.",
                 full_cnt, empty_cnt);
        if (err_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Result side: random back-pressure, two long hold-offs to fill the block
    initial
    begin : result_side
        int unsigned gap, taken;
        bit          r_steady;
        taken    = 0;
        r_steady = 1'b0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (taken == 400 || taken == 1200)
                gap = LONG_HOLD;
            else
                gap = r_steady ? 0 : $urandom_range(0, 4);
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            taken++;
            if (taken % 50 == 0)
                r_steady = ($urandom_range(0, 3) == 0);
        end
    end

    // Output word fields
    wire signed [VAL_W-1:0] got_front = m_tdata[VAL_W-1:0];
    wire signed [VAL_W-1:0] got_back  = m_tdata[2*VAL_W-1:VAL_W];
    wire [CNT_W-1:0]        got_count = m_tdata[2*VAL_W +: CNT_W];

    // Compare each result word with the oldest expectation
    always @(posedge clk)
    begin : result_check
        deque_view_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending.size() == 0)
            begin
                err_cnt++;
                $display("%0t: unexpected result word, expected none, got front %0d back %0d",
                         $time, got_front, got_back);
            end
            else
            begin
                want = pending.pop_front();
                if (got_front !== want.front)
                begin
                    err_cnt++;
                    $display("%0t: front_value expected %0d, got %0d",
                             $time, want.front, got_front);
                end
                if (got_back !== want.back)
                begin
                    err_cnt++;
                    $display("%0t: back_value expected %0d, got %0d",
                             $time, want.back, got_back);
                end
                if (got_count !== want.count)
                begin
                    err_cnt++;
                    $display("%0t: element_count expected %0d, got %0d",
                             $time, want.count, got_count);
                end
                if (m_tuser !== want.status)
                begin
                    err_cnt++;
                    $display("%0t: status expected %0d, got %0d",
                             $time, want.status, m_tuser);
                end
            end
        end
    end

    // Watchdog: too long without any word moving on either side
    initial
    begin : watchdog
        int unsigned idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
